@@ rtl/cle_pkg.sv @@
// Shared constants, microcode word type and microcode table for the line editor.
package cle_pkg;

	// Line store geometry
	localparam int LINE_LEN = 32;
	localparam int ADDR_W   = $clog2(LINE_LEN);
	localparam int CNT_W    = 6;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_LEN - 1);

	// Result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Key codes
	localparam logic [7:0] KEY_BS    = 8'd8;
	localparam logic [7:0] KEY_TAB   = 8'd9;
	localparam logic [7:0] KEY_LF    = 8'd10;
	localparam logic [7:0] KEY_CR    = 8'd13;
	localparam logic [7:0] KEY_SP    = 8'd32;
	localparam logic [7:0] KEY_TILDE = 8'd126;
	localparam logic [7:0] KEY_DEL   = 8'd127;

	// Data source select
	localparam logic [2:0] SRC_KEY = 3'd0;
	localparam logic [2:0] SRC_LF  = 3'd1;
	localparam logic [2:0] SRC_BS  = 3'd2;
	localparam logic [2:0] SRC_SP  = 3'd3;
	localparam logic [2:0] SRC_MEM = 3'd4;
	localparam logic [2:0] SRC_LEN = 3'd5;

	// Last flag select
	localparam logic [1:0] LAST_NO    = 2'd0;
	localparam logic [1:0] LAST_YES   = 2'd1;
	localparam logic [1:0] LAST_EMPTY = 2'd2;

	// Jump conditions
	localparam logic [1:0] J_NONE  = 2'd0;
	localparam logic [1:0] J_EMPTY = 2'd1;
	localparam logic [1:0] J_FULL  = 2'd2;
	localparam logic [1:0] J_MORE  = 2'd3;

	// Datapath actions
	localparam logic [2:0] A_NONE    = 3'd0;
	localparam logic [2:0] A_WRITE   = 3'd1;
	localparam logic [2:0] A_DEC     = 3'd2;
	localparam logic [2:0] A_CLR_IDX = 3'd3;
	localparam logic [2:0] A_READ    = 3'd4;
	localparam logic [2:0] A_CLR_CNT = 3'd5;

	// Program addresses
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] U_NL   = 4'd0;
	localparam logic [PC_W-1:0] U_NL_RD = 4'd1;
	localparam logic [PC_W-1:0] U_NL_OUT = 4'd2;
	localparam logic [PC_W-1:0] U_NL_END = 4'd3;
	localparam logic [PC_W-1:0] U_BS   = 4'd4;
	localparam logic [PC_W-1:0] U_TAB  = 4'd8;
	localparam logic [PC_W-1:0] U_PR   = 4'd12;
	localparam logic [PC_W-1:0] U_END  = 4'd14;

	typedef struct packed {
		logic            emit;   // step produces a result
		logic            echo;   // result is an echo, suppressed when echo is off
		logic [1:0]      kind;
		logic [2:0]      src;
		logic [1:0]      last;
		logic [1:0]      jcond;
		logic [PC_W-1:0] jtgt;
		logic [2:0]      act;
		logic            fin;    // program ends after this step
	} ucw_t;

	function automatic ucw_t uc(input logic emit, input logic echo, input logic [1:0] kind,
			input logic [2:0] src, input logic [1:0] last, input logic [1:0] jcond,
			input logic [PC_W-1:0] jtgt, input logic [2:0] act, input logic fin);
		ucw_t w;
		w.emit  = emit;
		w.echo  = echo;
		w.kind  = kind;
		w.src   = src;
		w.last  = last;
		w.jcond = jcond;
		w.jtgt  = jtgt;
		w.act   = act;
		w.fin   = fin;
		return w;
	endfunction

	// Microcode ROM
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			// newline: echo LF, then on a non-empty line walk the store, end marker, clear
			4'd0:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_LF, LAST_EMPTY, J_EMPTY, U_END,
					A_CLR_IDX, 1'b0);
			4'd1:  w = uc(1'b0, 1'b0, KIND_ECHO, SRC_KEY, LAST_NO, J_NONE, U_END,
					A_READ, 1'b0);
			4'd2:  w = uc(1'b1, 1'b0, KIND_LINE, SRC_MEM, LAST_NO, J_MORE, U_NL_RD,
					A_NONE, 1'b0);
			4'd3:  w = uc(1'b1, 1'b0, KIND_END, SRC_LEN, LAST_YES, J_NONE, U_END,
					A_CLR_CNT, 1'b1);
			// erase: skip on empty line, else drop one byte and echo BS SP BS
			4'd4:  w = uc(1'b0, 1'b0, KIND_ECHO, SRC_KEY, LAST_NO, J_EMPTY, U_END,
					A_NONE, 1'b0);
			4'd5:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_BS, LAST_NO, J_NONE, U_END,
					A_DEC, 1'b0);
			4'd6:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_SP, LAST_NO, J_NONE, U_END,
					A_NONE, 1'b0);
			4'd7:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_BS, LAST_YES, J_NONE, U_END,
					A_NONE, 1'b1);
			// tab: four spaces
			4'd8:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_SP, LAST_NO, J_NONE, U_END,
					A_NONE, 1'b0);
			4'd9:  w = uc(1'b1, 1'b1, KIND_ECHO, SRC_SP, LAST_NO, J_NONE, U_END,
					A_NONE, 1'b0);
			4'd10: w = uc(1'b1, 1'b1, KIND_ECHO, SRC_SP, LAST_NO, J_NONE, U_END,
					A_NONE, 1'b0);
			4'd11: w = uc(1'b1, 1'b1, KIND_ECHO, SRC_SP, LAST_YES, J_NONE, U_END,
					A_NONE, 1'b1);
			// printable: drop when full, else store and echo
			4'd12: w = uc(1'b0, 1'b0, KIND_ECHO, SRC_KEY, LAST_NO, J_FULL, U_END,
					A_NONE, 1'b0);
			4'd13: w = uc(1'b1, 1'b1, KIND_ECHO, SRC_KEY, LAST_YES, J_NONE, U_END,
					A_WRITE, 1'b1);
			// common exit
			default: w = uc(1'b0, 1'b0, KIND_ECHO, SRC_KEY, LAST_NO, J_NONE, U_END,
					A_NONE, 1'b1);
		endcase
		return w;
	endfunction

endpackage

@@ rtl/cle_if.sv @@
// Channel interfaces: key input, result output and echo configuration.
interface cle_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key;
	modport source (output valid, output key, input ready);
	modport sink (input valid, input key, output ready);
endinterface

interface cle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, output kind, output data_byte, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input last, output ready);
endinterface

interface cle_cfg_if;
	logic valid;
	logic ready;
	logic echo_enable;
	modport source (output valid, output echo_enable, input ready);
	modport sink (input valid, input echo_enable, output ready);
endinterface

@@ rtl/cle_line_mem.sv @@
// Line store: one write port, one read port with registered read data.
module cle_line_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [cle_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [cle_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);
	import cle_pkg::*;

	logic [7:0] mem [LINE_LEN];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/canonical_line_editor_top.sv @@
// Canonical line editor: microcoded sequencer over a line store and fill count.
//
//  channel  | dir | payload          | note
//  ---------+-----+------------------+-------------------------------------
//  key_ch   | in  | key[7:0]         | one key byte per item
//  res_ch   | out | kind, data_byte, | echo, line byte or end marker,
//           |     | last             | last marks the key's final result
//  cfg_ch   | in  | echo_enable      | always ready, write only when idle
//
// A key is taken only while the sequencer is idle; the sequencer then runs one
// microcode step per cycle while not stalled: 1 step (ignored), 2 (printable,
// erase on empty, newline on empty), 4 (erase), 4 (tab), or 2 + 2 per stored
// byte for a newline, the line walk reading the store one byte every two steps.
// A step that emits waits while the output register is full and not being taken.
// Reset clears the count, the sequencer and the output register and sets echo on;
// the store is left as it is.
module canonical_line_editor_top (
	input  logic      clk,
	input  logic      arst_n,
	cle_key_if.sink   key_ch,
	cle_res_if.source res_ch,
	cle_cfg_if.sink   cfg_ch
);
	import cle_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0]      key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic            echo_en_q;
	logic            out_v_q;
	logic [1:0]      kind_q;
	logic [7:0]      data_q;
	logic            last_q;

	ucw_t            uw;
	logic            key_acc;
	logic            slot_free;
	logic            show;
	logic            fire;
	logic            empty;
	logic            full;
	logic            more;
	logic            take_jump;
	logic            last_bit;
	logic [7:0]      res_data;
	logic [7:0]      mem_rd;
	logic [PC_W-1:0] entry;

	// microcode fetch and step qualifiers
	assign uw        = ucode(pc_q);
	assign key_acc   = key_ch.valid && key_ch.ready;
	assign slot_free = !out_v_q || res_ch.ready;
	assign show      = uw.emit && (!uw.echo || echo_en_q);
	assign fire      = busy_q && (!show || slot_free);
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CNT_FULL);
	assign more      = (idx_q < cnt_q);

	assign key_ch.ready = !busy_q;
	assign cfg_ch.ready = 1'b1;

	// key class to program entry
	always_comb begin
		case (key_ch.key) inside
			KEY_LF, KEY_CR:        entry = U_NL;
			KEY_BS, KEY_DEL:       entry = U_BS;
			KEY_TAB:               entry = U_TAB;
			[KEY_SP:KEY_TILDE]:    entry = U_PR;
			default:               entry = U_END;
		endcase
	end

	// jump condition
	always_comb begin
		unique case (uw.jcond)
			J_EMPTY: take_jump = empty;
			J_FULL:  take_jump = full;
			J_MORE:  take_jump = more;
			default: take_jump = 1'b0;
		endcase
	end

	// last flag
	always_comb begin
		unique case (uw.last)
			LAST_YES:   last_bit = 1'b1;
			LAST_EMPTY: last_bit = empty;
			default:    last_bit = 1'b0;
		endcase
	end

	// result data select
	always_comb begin
		unique case (uw.src)
			SRC_LF:  res_data = KEY_LF;
			SRC_BS:  res_data = KEY_BS;
			SRC_SP:  res_data = KEY_SP;
			SRC_MEM: res_data = mem_rd;
			SRC_LEN: res_data = 8'(cnt_q);
			default: res_data = key_q;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= U_END;
		end else if (key_acc) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (fire) begin
			if (uw.fin) begin
				busy_q <= 1'b0;
			end else if (take_jump) begin
				pc_q <= uw.jtgt;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// key holding register
	always_ff @(posedge clk) begin
		if (key_acc) begin
			key_q <= key_ch.key;
		end
	end

	// fill count and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (fire) begin
			case (uw.act)
				A_WRITE:   cnt_q <= cnt_q + 1'b1;
				A_DEC:     cnt_q <= cnt_q - 1'b1;
				A_CLR_IDX: idx_q <= '0;
				A_READ:    idx_q <= idx_q + 1'b1;
				A_CLR_CNT: cnt_q <= '0;
				default:   ;
			endcase
		end
	end

	cle_line_mem u_mem (
		.clk   (clk),
		.we    (fire && (uw.act == A_WRITE)),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (key_q),
		.re    (fire && (uw.act == A_READ)),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (mem_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire && show) begin
			out_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && show) begin
			kind_q <= uw.kind;
			data_q <= res_data;
			last_q <= last_bit;
		end
	end

	assign res_ch.valid     = out_v_q;
	assign res_ch.kind      = kind_q;
	assign res_ch.data_byte = data_q;
	assign res_ch.last      = last_q;

	// echo enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q <= 1'b1;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			echo_en_q <= cfg_ch.echo_enable;
		end
	end

	// fill count never passes the usable line length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("line count beyond line length");

	// an end marker leaves the line empty
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && show && (uw.kind == KIND_END)) |=> (cnt_q == '0))
		else $error("line not cleared after end marker");

	// line walk never reads past the fill count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (pc_q == U_NL_OUT)) |-> (idx_q <= cnt_q && idx_q != '0))
		else $error("line walk index out of range");

endmodule

@@ test/cle_checker.sv @@
// Line editor checker: watches the key, result and echo channels, predicts and compares.
module cle_checker
	import cle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cle_key_if   key_ch,
	cle_res_if   res_ch,
	cle_cfg_if   cfg_ch,
	output int   errors,
	output int   pending,
	output int   checked
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} res_t;

	// Shadow of the editor state
	logic [7:0]       line_buf [LINE_LEN];
	logic [CNT_W-1:0] line_len;
	logic             echo_on;
	res_t             res_exp_q [$];

	// Work out every result one key causes and queue them
	function automatic void edit_line(input logic [7:0] k);
		res_t q [$];
		int   i;
		if (k == KEY_LF || k == KEY_CR) begin
			if (echo_on)
				q.push_back(res_t'{KIND_ECHO, KEY_LF, 1'b0});
			if (line_len != '0) begin
				for (i = 0; i < int'(line_len); i++)
					q.push_back(res_t'{KIND_LINE, line_buf[i], 1'b0});
				q.push_back(res_t'{KIND_END, 8'(line_len), 1'b0});
			end
			line_len = '0;
		end else if (k == KEY_BS || k == KEY_DEL) begin
			// erase on an empty line does nothing
			if (line_len != '0) begin
				line_len = line_len - 1'b1;
				if (echo_on) begin
					q.push_back(res_t'{KIND_ECHO, KEY_BS, 1'b0});
					q.push_back(res_t'{KIND_ECHO, KEY_SP, 1'b0});
					q.push_back(res_t'{KIND_ECHO, KEY_BS, 1'b0});
				end
			end
		end else if (k == KEY_TAB) begin
			if (echo_on)
				for (i = 0; i < 4; i++)
					q.push_back(res_t'{KIND_ECHO, KEY_SP, 1'b0});
		end else if (k >= KEY_SP && k <= KEY_TILDE) begin
			// full line drops the byte silently
			if (line_len < CNT_FULL) begin
				line_buf[line_len[ADDR_W-1:0]] = k;
				line_len = line_len + 1'b1;
				if (echo_on)
					q.push_back(res_t'{KIND_ECHO, k, 1'b0});
			end
		end
		if (q.size() > 0)
			q[q.size()-1].last = 1'b1;
		foreach (q[i])
			res_exp_q.push_back(q[i]);
	endfunction

	// Monitor: register writes, keys, then results
	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			line_len = '0;
			echo_on  = 1'b1;
			res_exp_q.delete();
			errors   = 0;
			checked  = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				echo_on = cfg_ch.echo_enable;
			if (key_ch.valid && key_ch.ready)
				edit_line(key_ch.key);
			if (res_ch.valid && res_ch.ready) begin
				got = res_t'{res_ch.kind, res_ch.data_byte, res_ch.last};
				checked++;
				if (res_exp_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected item: kind %0d byte %02h last %0d",
							got.kind, got.data_byte, got.last);
				end else begin
					want = res_exp_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected kind %0d byte %02h last %0d,",
								" got kind %0d byte %02h last %0d"},
								want.kind, want.data_byte, want.last,
								got.kind, got.data_byte, got.last);
					end
				end
			end
		end
		pending = res_exp_q.size();
	end

endmodule

@@ test/canonical_line_editor_top_tb.sv @@
// Testbench top for the line editor: clock, reset, key and echo stimulus, verdict.
module canonical_line_editor_top_tb;
	import cle_pkg::*;

	localparam logic [7:0] KEY_ESC   = 8'd27;
	localparam int         STALL_MAX = 2000;
	localparam int         PHASE_N   = 130;

	logic clk;
	logic arst_n;
	int   src_idle;
	int   snk_idle;
	int   errors;
	int   pending;
	int   checked;
	int   n_keys;
	int   n_cfg;
	int   n_items;
	int   stall;

	cle_key_if key_ch ();
	cle_res_if res_ch ();
	cle_cfg_if cfg_ch ();

	canonical_line_editor_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key_ch (key_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	cle_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_ch  (key_ch),
		.res_ch  (res_ch),
		.cfg_ch  (cfg_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result receiver stalls at random
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				stall <= 0;
			else
				stall <= stall + 1;
			if (stall >= STALL_MAX) begin
				$display("watchdog: no progress for %0d cycles, %0d results outstanding",
					stall, pending);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// One key item, with a random gap ahead of it; valid stays high afterwards
	task automatic send_key(input logic [7:0] k);
		if ($urandom_range(99) < src_idle) begin
			key_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < src_idle);
		end
		key_ch.valid <= 1'b1;
		key_ch.key   <= k;
		do @(posedge clk); while (!key_ch.ready);
		n_keys++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected result is in
	task automatic settle();
		key_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_echo(input logic v);
		settle();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.echo_enable <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		n_cfg++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// One typed line, in random mode with edits and some noise, closed by CR or LF
	task automatic type_line(input bit full);
		int         len, j, r;
		logic [7:0] k;
		if (full)
			len = 34;
		else
			len = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
		for (j = 0; j < len; j++) begin
			r = full ? 0 : $urandom_range(99);
			if (r < 78)
				k = 8'($urandom_range(32, 126));
			else if (r < 86)
				k = $urandom_range(1) ? KEY_BS : KEY_DEL;
			else if (r < 90)
				k = KEY_TAB;
			else
				k = 8'($urandom_range(255));
			send_key(k);
			n_items++;
		end
		send_key($urandom_range(1) ? KEY_CR : KEY_LF);
		n_items++;
	endtask

	task automatic run_phase(input int s_idle, input int r_idle, input logic echo_v);
		int target;
		src_idle = s_idle;
		snk_idle = r_idle;
		set_echo(echo_v);
		target = n_items + PHASE_N;
		type_line(1'b1);
		while (n_items < target) begin
			type_line(1'b0);
			// now and then hold off until the block has drained
			if ($urandom_range(11) == 0)
				settle();
			// flip echo halfway through the last phase
			if (s_idle == 0 && n_items >= target - PHASE_N / 2 && n_cfg == 5)
				set_echo(~echo_v);
		end
	endtask

	// Stimulus and verdict
	initial begin
		logic [7:0] dir_on [14];
		logic [7:0] dir_off [6];
		dir_on  = '{KEY_BS, 8'h41, KEY_SP, KEY_TILDE, KEY_TAB, KEY_DEL, KEY_BS, KEY_CR,
			KEY_LF, KEY_ESC, 8'h00, 8'hFF, 8'h80, 8'h1F};
		dir_off = '{8'h62, KEY_TAB, KEY_BS, KEY_LF, 8'h63, KEY_CR};
		arst_n             = 1'b0;
		key_ch.valid       = 1'b0;
		key_ch.key         = 8'h00;
		cfg_ch.valid       = 1'b0;
		cfg_ch.echo_enable = 1'b0;
		src_idle           = 10;
		snk_idle           = 48;
		n_keys             = 0;
		n_cfg              = 0;
		n_items            = 0;
		stall              = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: echo on from reset, then echo off
		foreach (dir_on[i])
			send_key(dir_on[i]);
		set_echo(1'b0);
		foreach (dir_off[i])
			send_key(dir_off[i]);
		set_echo(1'b1);

		// random lines under three idling patterns
		run_phase(10, 48, 1'b1);
		run_phase(48, 10, 1'b0);
		run_phase(0, 0, 1'b1);

		settle();
		$display("Run covered %0d keys and %0d result items under %0d echo register writes,",
			n_keys, checked, n_cfg);
		$display("with erases, tabs, full and empty lines and ignored bytes; %0d failures.",
			errors + pending);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
